@@ sv/counter_label_formatter_core_assert.svh @@
// Assertion macros for the label formatter checker
`ifndef COUNTER_LABEL_FORMATTER_CORE_ASSERT_SVH
`define COUNTER_LABEL_FORMATTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CLF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("label formatter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("label formatter check failed");

`endif

@@ sv/clfmt_pkg.sv @@
// Shared types, constants and lookup functions of the label formatter
package clfmt_pkg;

  localparam int VALUE_W = 16;
  localparam int CHAR_W  = 16;
  localparam int REM_W   = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Label forms selected by the mode register
  typedef enum logic [1:0] {
    MODE_DIGIT = 2'd0,
    MODE_ALPHA = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_ROMAN = 2'd3
  } label_mode_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_CASE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_BASE = 2'd2;

  localparam char_t DIGIT_BASE_RESET = 16'd48;

  // Letter codes
  localparam logic [6:0] LETTER_A_UP = 7'h41;
  localparam logic [6:0] LETTER_A_LO = 7'h61;
  localparam char_t      CASE_OFFSET = 16'd32;

  localparam logic [11:0] ROMAN_MAX = 12'd3999;

  // Reciprocal constants: (n * M) >> S equals n / D for every 16-bit n
  localparam logic [15:0] MAGIC_DIV10 = 16'd52429;
  localparam int          SHIFT_DIV10 = 19;
  localparam logic [15:0] MAGIC_DIV26 = 16'd40330;
  localparam int          SHIFT_DIV26 = 20;

  typedef enum logic [1:0] {
    DIV_10 = 2'b01,
    DIV_26 = 2'b10
  } div_sel_t;

  typedef struct packed {
    logic     load;
    div_sel_t sel;
    value_t   dividend;
  } div_req_t;

  typedef struct packed {
    value_t           quot;
    logic [REM_W-1:0] rem;
  } div_res_t;

  // Roman table: value of each step, largest first
  function automatic logic [9:0] roman_value(input logic [3:0] idx);
    logic [9:0] v;
    case (idx)
      4'd0:    v = 10'd1000;
      4'd1:    v = 10'd900;
      4'd2:    v = 10'd500;
      4'd3:    v = 10'd400;
      4'd4:    v = 10'd100;
      4'd5:    v = 10'd90;
      4'd6:    v = 10'd50;
      4'd7:    v = 10'd40;
      4'd8:    v = 10'd10;
      4'd9:    v = 10'd9;
      4'd10:   v = 10'd5;
      4'd11:   v = 10'd4;
      4'd12:   v = 10'd1;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

  // First capital letter of each step
  function automatic logic [6:0] roman_sym0(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'h4D;   // M
      4'd1:    c = 7'h43;   // C of CM
      4'd2:    c = 7'h44;   // D
      4'd3:    c = 7'h43;   // C of CD
      4'd4:    c = 7'h43;   // C
      4'd5:    c = 7'h58;   // X of XC
      4'd6:    c = 7'h4C;   // L
      4'd7:    c = 7'h58;   // X of XL
      4'd8:    c = 7'h58;   // X
      4'd9:    c = 7'h49;   // I of IX
      4'd10:   c = 7'h56;   // V
      4'd11:   c = 7'h49;   // I of IV
      4'd12:   c = 7'h49;   // I
      default: c = 7'h49;
    endcase
    return c;
  endfunction

  // Second capital letter of the subtractive steps
  function automatic logic [6:0] roman_sym1(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd1:    c = 7'h4D;   // M
      4'd3:    c = 7'h44;   // D
      4'd5:    c = 7'h43;   // C
      4'd7:    c = 7'h4C;   // L
      4'd9:    c = 7'h58;   // X
      4'd11:   c = 7'h56;   // V
      default: c = 7'h49;
    endcase
    return c;
  endfunction

  // Subtractive steps carry two letters
  function automatic logic roman_pair(input logic [3:0] idx);
    return idx[0] && (idx < 4'd12);
  endfunction

endpackage

@@ sv/clfmt_in_if.sv @@
// Input channel: one counter value per transaction
interface clfmt_in_if import clfmt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t counter_value;

  modport source (output valid, output counter_value, input ready);
  modport sink   (input valid, input counter_value, output ready);
endinterface

@@ sv/clfmt_out_if.sv @@
// Result channel: one label character per transaction
interface clfmt_out_if import clfmt_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;
  logic  error;

  modport source (output valid, output char_code, output last, output error, input ready);
  modport sink   (input valid, input char_code, input last, input error, output ready);
endinterface

@@ sv/clfmt_ram.sv @@
// Generic single-port-write, registered-read RAM
module clfmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/clfmt_divider.sv @@
// Shared divide-by-10 / divide-by-26 unit: registered reciprocal product, then quotient
module clfmt_divider import clfmt_pkg::*; (
  input  logic     clk,
  input  div_req_t req,
  output div_res_t res
);

  logic [31:0] prod_r;
  div_sel_t    sel_r;
  value_t      dividend_r;
  value_t      quot;
  value_t      qd;
  value_t      diff;

  // Capture the reciprocal product
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_r     <= {16'd0, req.dividend} *
                    {16'd0, (req.sel == DIV_10) ? MAGIC_DIV10 : MAGIC_DIV26};
      sel_r      <= req.sel;
      dividend_r <= req.dividend;
    end
  end

  // Quotient from the product, remainder by shift-add back-multiply
  always_comb begin
    if (sel_r == DIV_10) begin
      quot = value_t'(prod_r >> SHIFT_DIV10);
      qd   = (quot << 3) + (quot << 1);
    end else begin
      quot = value_t'(prod_r >> SHIFT_DIV26);
      qd   = (quot << 4) + (quot << 3) + (quot << 1);
    end
    diff     = dividend_r - qd;
    res.quot = quot;
    res.rem  = diff[REM_W-1:0];
  end

endmodule

@@ sv/counter_label_formatter_core.sv @@
// Top level of the counter label formatter
// Usage:
//   in_ch carries one counter value per transaction; out_ch returns the label
//   one character per transaction, most significant first, with last set on
//   the final character. A value with no label in the current form gives a
//   single result with char_code zero, last and error set.
//   cfg_wr_en / cfg_index / cfg_wdata write label_mode (0), upper_case (1)
//   and digit_base (2); write them only while the block is idle.
// Timing:
//   The block takes one value at a time; in_ch.ready is high only when idle.
//   Digit and alphabetic labels run the shared constant divider once per
//   character, then stream from the label RAM at one character a cycle while
//   out_ch.ready stays high. Roman labels walk the table step by step, writing
//   each letter in turn; synchronized labels pass through S_DIV, S_DIGIT and
//   S_RD before streaming.
// Reset and stall:
//   rst_n holds in_ch.ready low, clears the sequencer state and out_valid_r
//   and loads the register defaults (digits, lower case, digit zero = 48).
//   A low out_ch.ready freezes the output register and the stream; the final
//   character may wait while the next value is already accepted.
module counter_label_formatter_core import clfmt_pkg::*; #(
  parameter int MAX_LABEL = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  clfmt_in_if.sink               in_ch,
  clfmt_out_if.source            out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LEN_W  = $clog2(MAX_LABEL + 1);
  localparam int ADDR_W = $clog2(MAX_LABEL);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_DIGIT = 7'b0000100,
    S_ROMAN = 7'b0001000,
    S_RD    = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  // Configuration registers
  label_mode_t label_mode_r;
  logic        upper_case_r;
  char_t       digit_base_r;

  // Sequencer state
  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [11:0]      rom_n_r, rom_n_nxt;
  logic [3:0]       rom_idx_r, rom_idx_nxt;
  logic             rom_half_r, rom_half_nxt;
  char_t            sync_char_r, sync_char_nxt;

  // Output register
  logic  out_valid_r;
  char_t out_char_r;
  logic  out_last_r;
  logic  out_err_r;
  logic  out_load;
  char_t out_char_d;
  logic  out_last_d;
  logic  out_err_d;
  logic  out_free;

  // Divider and RAM hookup
  div_req_t          div_req;
  div_res_t          div_res;
  logic              wr_en;
  char_t             wr_data;
  logic              rd_en;
  logic [LEN_W-1:0]  rd_pos;
  logic [LEN_W-1:0]  rd_idx;
  char_t             ram_rdata;

  logic              reverse;
  logic              sync_mode;
  char_t             letter0;
  char_t             roman_shift;
  logic [11:0]       rom_val;

  clfmt_divider u_div (
    .clk (clk),
    .req (div_req),
    .res (div_res)
  );

  clfmt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LABEL)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_mode_r <= MODE_DIGIT;
      upper_case_r <= 1'b0;
      digit_base_r <= DIGIT_BASE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LABEL_MODE: label_mode_r <= label_mode_t'(cfg_wdata[1:0]);
        CFG_UPPER_CASE: upper_case_r <= cfg_wdata[0];
        CFG_DIGIT_BASE: digit_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mode-derived helpers
  assign reverse     = (label_mode_r == MODE_DIGIT) || (label_mode_r == MODE_ALPHA);
  assign sync_mode   = (label_mode_r == MODE_SYNC);
  assign letter0     = {9'd0, upper_case_r ? LETTER_A_UP : LETTER_A_LO};
  assign roman_shift = upper_case_r ? 16'd0 : CASE_OFFSET;
  assign rom_val     = {2'd0, roman_value(rom_idx_r)};
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // Read address: reversed for digit and alphabetic labels
  assign rd_pos = (state_r == S_LOAD) ? pos_r + 1'b1 : pos_r;
  assign rd_idx = reverse ? len_r - 1'b1 - rd_pos : rd_pos;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    rom_n_nxt     = rom_n_r;
    rom_idx_nxt   = rom_idx_r;
    rom_half_nxt  = rom_half_r;
    sync_char_nxt = sync_char_r;
    div_req       = '{load: 1'b0, sel: DIV_10, dividend: '0};
    wr_en         = 1'b0;
    wr_data       = '0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    out_char_d    = '0;
    out_last_d    = 1'b0;
    out_err_d     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          len_nxt      = '0;
          pos_nxt      = '0;
          rom_n_nxt    = in_ch.counter_value[11:0];
          rom_idx_nxt  = '0;
          rom_half_nxt = 1'b0;
          if (in_ch.counter_value == '0 ||
              (label_mode_r == MODE_ROMAN &&
               in_ch.counter_value > {4'd0, ROMAN_MAX})) begin
            state_nxt = S_ERR;
          end else begin
            unique case (label_mode_r)
              MODE_DIGIT: begin
                div_req   = '{load: 1'b1, sel: DIV_10, dividend: in_ch.counter_value};
                state_nxt = S_DIV;
              end
              MODE_ALPHA, MODE_SYNC: begin
                div_req   = '{load: 1'b1, sel: DIV_26,
                              dividend: in_ch.counter_value - 1'b1};
                state_nxt = S_DIV;
              end
              MODE_ROMAN: state_nxt = S_ROMAN;
              default:    state_nxt = S_ERR;
            endcase
          end
        end
      end

      S_DIV: state_nxt = S_DIGIT;

      S_DIGIT: begin
        if (sync_mode) begin
          // One letter repeated quotient+1 times
          if (div_res.quot >= value_t'(MAX_LABEL)) begin
            state_nxt = S_ERR;
          end else begin
            len_nxt       = LEN_W'(div_res.quot + 1'b1);
            sync_char_nxt = letter0 + char_t'(div_res.rem);
            state_nxt     = S_RD;
          end
        end else begin
          // Store one character, least significant first
          wr_en   = 1'b1;
          wr_data = (label_mode_r == MODE_DIGIT) ? digit_base_r + char_t'(div_res.rem)
                                                 : letter0 + char_t'(div_res.rem);
          len_nxt = len_r + 1'b1;
          if (div_res.quot == '0) begin
            state_nxt = S_RD;
          end else begin
            div_req.load     = 1'b1;
            div_req.sel      = (label_mode_r == MODE_DIGIT) ? DIV_10 : DIV_26;
            div_req.dividend = (label_mode_r == MODE_DIGIT) ? div_res.quot
                                                            : div_res.quot - 1'b1;
            state_nxt        = S_DIV;
          end
        end
      end

      S_ROMAN: begin
        if (rom_half_r) begin
          // Second letter of a subtractive pair
          wr_en        = 1'b1;
          wr_data      = {9'd0, roman_sym1(rom_idx_r)} + roman_shift;
          len_nxt      = len_r + 1'b1;
          rom_half_nxt = 1'b0;
        end else if (rom_n_r == '0) begin
          state_nxt = S_RD;
        end else if (rom_n_r >= rom_val) begin
          wr_en        = 1'b1;
          wr_data      = {9'd0, roman_sym0(rom_idx_r)} + roman_shift;
          len_nxt      = len_r + 1'b1;
          rom_n_nxt    = rom_n_r - rom_val;
          rom_half_nxt = roman_pair(rom_idx_r);
        end else begin
          rom_idx_nxt = rom_idx_r + 1'b1;
        end
      end

      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        // Stream one character per free output slot, prefetching the next
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = sync_mode ? sync_char_r : ram_rdata;
          out_last_d = (pos_r + 1'b1 == len_r);
          if (out_last_d) begin
            pos_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = '0;
          out_last_d = 1'b1;
          out_err_d  = 1'b1;
          len_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      pos_r      <= '0;
      rom_half_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      rom_half_r <= rom_half_nxt;
    end
  end

  // Working payload, no reset needed
  always_ff @(posedge clk) begin
    rom_n_r     <= rom_n_nxt;
    rom_idx_r   <= rom_idx_nxt;
    sync_char_r <= sync_char_nxt;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= out_char_d;
      out_last_r <= out_last_d;
      out_err_r  <= out_err_d;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.error     = out_err_r;

endmodule

@@ sv/clfmt_checker.sv @@
// Port-level checker for the label formatter, bound to the top level
`include "counter_label_formatter_core_assert.svh"

module clfmt_checker import clfmt_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_char_code,
  input logic  out_last,
  input logic  out_error
);

  // An error result is a single zero character
  `CLF_ASSERT_IMPL(a_error_shape, out_valid && out_error, out_last && out_char_code == '0)

  // A taken value blocks the next one
  `CLF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // No new value while a label is still mid-stream
  `CLF_ASSERT_IMPL(a_no_accept_mid_label, out_valid && !out_last, !in_ready)

  // A stalled result holds
  `CLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_char_code) && $stable(out_last))

endmodule

bind counter_label_formatter_core clfmt_checker u_clfmt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char_code (out_ch.char_code),
  .out_last      (out_ch.last),
  .out_error     (out_ch.error)
);
